// File: rtl/ssba_pkg.sv
// ----------------------------------------------------------------------------
// ssba_pkg: swap slot bitmap allocator shared definitions
// Sizes, request codes, controller states and the command and status groups
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssba_pkg;

  // geometry of the slot space and of one sector run
  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_PAGE = 8;
  localparam int RESULT_LIMIT     = 8;
  localparam int RUN_LEN          = (SECTORS_PER_PAGE > RESULT_LIMIT) ?
                                    RESULT_LIMIT : SECTORS_PER_PAGE;
  localparam int BEAT_W           = (RUN_LEN > 1) ? $clog2(RUN_LEN) : 1;

  // field widths
  localparam int SLOT_W   = 10;
  localparam int SECTOR_W = 13;
  localparam int COUNT_W  = 11;

  // bitmap kept as rows of a memory
  localparam int ROW_BITS = 32;
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int ROWS     = MAX_SLOTS / ROW_BITS;
  localparam int ROW_W    = SLOT_W - BIT_W;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = COUNT_W'(MAX_SLOTS);

  // request codes
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;    // capture request, select starting row
    logic read;      // read current bitmap row
    logic next_row;  // step scan to next row
    logic commit;    // update row, start success run
    logic fail;      // start single failure beat
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_release;
    logic hit;        // free slot found, or released slot is in use
    logic more;       // further rows lie below the limit
    logic run_done;   // last beat taken
  } sts_t;

endpackage

// File: rtl/ssba_if.sv
// ----------------------------------------------------------------------------
// ssba_req_if / ssba_rsp_if: request and result channels
// Valid/ready channels carrying one request or one result beat.
// ----------------------------------------------------------------------------
interface ssba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [ssba_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

interface ssba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ssba_pkg::SLOT_W-1:0]   slot;
  logic [ssba_pkg::SECTOR_W-1:0] sector;
  logic                         last;

  modport source (output valid, output ok, output slot, output sector, output last,
                  input ready);
  modport sink   (input valid, input ok, input slot, input sector, input last,
                  output ready);
endinterface

// File: rtl/ssba_ctrl.sv
// ----------------------------------------------------------------------------
// ssba_ctrl: request sequencer
// Steps each request through bitmap row reads, the check, and the result run.
// ----------------------------------------------------------------------------
module ssba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ssba_pkg::sts_t sts_i,
  output ssba_pkg::cmd_t cmd_o
);

  ssba_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ssba_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ssba_pkg::ST_READ;
        end
      end
      ssba_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ssba_pkg::ST_CHECK;
      end
      ssba_pkg::ST_CHECK: begin
        if (sts_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = ssba_pkg::ST_EMIT;
        end else if (!sts_i.is_release && sts_i.more) begin
          cmd_o.next_row = 1'b1;
          state_d        = ssba_pkg::ST_READ;
        end else begin
          cmd_o.fail = 1'b1;
          state_d    = ssba_pkg::ST_EMIT;
        end
      end
      ssba_pkg::ST_EMIT: begin
        if (sts_i.run_done) begin
          state_d = ssba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ssba_dpath.sv
// ----------------------------------------------------------------------------
// ssba_dpath: bitmap store, slot search and result beat generator
// Holds the used-slot bitmap as rows of a memory with per-row valid bits,
// finds the lowest free slot in a row, and produces the sector beats.
// ----------------------------------------------------------------------------
module ssba_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssba_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [ssba_pkg::SLOT_W-1:0]   slot_index_i,
  input  ssba_pkg::cmd_t                cmd_i,
  output ssba_pkg::sts_t                sts_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          rsp_ok_o,
  output logic [ssba_pkg::SLOT_W-1:0]   rsp_slot_o,
  output logic [ssba_pkg::SECTOR_W-1:0] rsp_sector_o,
  output logic                          rsp_last_o
);

  localparam int RB = ssba_pkg::ROW_BITS;
  localparam int RW = ssba_pkg::ROW_W;
  localparam int BW = ssba_pkg::BIT_W;
  localparam int CW = ssba_pkg::COUNT_W;

  logic [RB-1:0]                 mem [ssba_pkg::ROWS];
  logic [ssba_pkg::ROWS-1:0]     row_vld_q;
  logic [RB-1:0]                 rd_data_q;
  logic                          rd_vld_q;
  logic [CW-1:0]                 slot_count_q;
  logic                          kind_q;
  logic [ssba_pkg::SLOT_W-1:0]   want_q;
  logic [RW-1:0]                 row_q;

  logic                          out_vld_q;
  logic                          out_ok_q;
  logic [ssba_pkg::SLOT_W-1:0]   out_slot_q;
  logic [ssba_pkg::BEAT_W-1:0]   beat_q;

  logic [CW-1:0]                 limit;
  logic [RB-1:0]                 row_word;
  logic [RB-1:0]                 free_vec;
  logic                          free_any;
  logic [BW-1:0]                 free_bit;
  logic [BW-1:0]                 hit_bit;
  logic [RB-1:0]                 wr_word;
  logic [RW:0]                   row_next;
  logic                          in_range;
  logic                          beat_last;
  logic                          beat_take;

  // usable slot limit, saturated at the bitmap size
  assign limit = (slot_count_q > ssba_pkg::SLOT_COUNT_RST) ?
                 ssba_pkg::SLOT_COUNT_RST : slot_count_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= ssba_pkg::SLOT_COUNT_RST;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  // request capture and row pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= req_type_i;
      want_q <= slot_index_i;
      row_q  <= (req_type_i == ssba_pkg::REQ_RELEASE) ? slot_index_i[ssba_pkg::SLOT_W-1:BW]
                                                      : '0;
    end else if (cmd_i.next_row) begin
      row_q <= row_q + RW'(1);
    end
  end

  // a row never written reads as all free
  assign row_word = rd_vld_q ? rd_data_q : '0;

  // free slots of the row that lie below the limit
  always_comb begin
    for (int i = 0; i < RB; i++) begin
      free_vec[i] = !row_word[i] && ({1'b0, row_q, BW'(i)} < limit);
    end
  end

  // lowest free slot in the row
  always_comb begin
    free_any = 1'b0;
    free_bit = '0;
    for (int i = RB - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_any = 1'b1;
        free_bit = BW'(i);
      end
    end
  end

  assign in_range = {1'b0, want_q} < limit;
  assign hit_bit  = (kind_q == ssba_pkg::REQ_RELEASE) ? want_q[BW-1:0] : free_bit;
  assign row_next = {1'b0, row_q} + (RW + 1)'(1);

  // set the bit on allocate, clear it on release
  always_comb begin
    wr_word = row_word;
    wr_word[hit_bit] = (kind_q == ssba_pkg::REQ_ALLOC);
  end

  // bitmap row store
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q <= mem[row_q];
    end
    if (cmd_i.commit) begin
      mem[row_q] <= wr_word;
    end
  end

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        rd_vld_q <= row_vld_q[row_q];
      end
      if (cmd_i.commit) begin
        row_vld_q[row_q] <= 1'b1;
      end
    end
  end

  // status to the controller
  assign beat_last = !out_ok_q || (beat_q == ssba_pkg::BEAT_W'(ssba_pkg::RUN_LEN - 1));
  assign beat_take = out_vld_q && rsp_ready_i;

  always_comb begin
    sts_o.is_release = (kind_q == ssba_pkg::REQ_RELEASE);
    sts_o.hit        = (kind_q == ssba_pkg::REQ_RELEASE) ?
                       (in_range && row_word[want_q[BW-1:0]]) : free_any;
    sts_o.more       = {row_next, BW'(0)} < limit;
    sts_o.run_done   = beat_take && beat_last;
  end

  // result beat control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.fail) begin
      out_vld_q <= 1'b1;
    end else if (beat_take && beat_last) begin
      out_vld_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_ok_q   <= 1'b1;
      out_slot_q <= {row_q, hit_bit};
      beat_q     <= '0;
    end else if (cmd_i.fail) begin
      out_ok_q   <= 1'b0;
      out_slot_q <= (kind_q == ssba_pkg::REQ_RELEASE) ? want_q : '0;
      beat_q     <= '0;
    end else if (beat_take && !beat_last) begin
      beat_q <= beat_q + ssba_pkg::BEAT_W'(1);
    end
  end

  assign rsp_valid_o  = out_vld_q;
  assign rsp_ok_o     = out_ok_q;
  assign rsp_slot_o   = out_slot_q;
  assign rsp_last_o   = beat_last;
  assign rsp_sector_o = out_ok_q ?
    ssba_pkg::SECTOR_W'(32'(out_slot_q) * ssba_pkg::SECTORS_PER_PAGE + 32'(beat_q)) : '0;

endmodule

// File: rtl/swap_slot_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_core: first-fit swap slot allocator
// Keeps a used bit per swap slot, allocates the lowest free slot or releases
// a named one, and emits the sector run of the slot.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beats per request
//  req_i    in   req_type, slot_index             1
//  rsp_o    out  ok, slot, sector, last           1 on failure, 8 on success
//  cfg      in   slot_count (cfg_we_i/cfg_wdata_i) n/a
//
//  release: accept, then a row read and the check, then the result beats
//  allocate: accept, then a row read and a check per 32-slot bitmap row scanned,
//    up to 32 rows, then the result beats
//  one request at a time: req_i is ready only once the last beat is taken
//  reset clears the per-row valid bits at once, so the bitmap reads all free
//  a stalled rsp_o holds its beat and the whole request waits on it
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssba_pkg::COUNT_W-1:0] cfg_wdata_i,
  ssba_req_if.sink                     req_i,
  ssba_rsp_if.source                   rsp_o
);

  ssba_pkg::cmd_t cmd;
  ssba_pkg::sts_t sts;
  logic           req_ready;

  // sequencer
  ssba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // bitmap and result datapath
  ssba_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_i.req_type),
    .slot_index_i (req_i.slot_index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_ok_o     (rsp_o.ok),
    .rsp_slot_o   (rsp_o.slot),
    .rsp_sector_o (rsp_o.sector),
    .rsp_last_o   (rsp_o.last)
  );

  // no result beat while a new request can be taken
  a_idle_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready && rsp_o.valid))
    else $error("result beat pending while request port is ready");

  // a failure is always a single last beat
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> rsp_o.last)
    else $error("failure beat not flagged last");

  // within a run the sector steps by one on each taken beat
  a_sector_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready && !rsp_o.last) |=>
      (rsp_o.valid && rsp_o.sector == $past(rsp_o.sector) + 13'd1))
    else $error("sector run not consecutive");

  // commit and fail never fire together
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.commit && cmd.fail))
    else $error("request both committed and failed");

endmodule

// File: bench/swap_slot_bitmap_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_core_tb: allocator bench
// Sends allocate and release requests through the request channel and checks
// every sector beat against a bit-accurate slot map kept on the bench side.
// Covers directed corner cases first (free releases, full map, out-of-range
// slots, zero and saturated slot counts), then random phases under several
// slot counts with random stalls on both channels and one long result stall.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_core_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 300;
  localparam int CFG_SETTLE   = 8;
  localparam int END_SETTLE   = 80;

  // one result beat as seen on rsp_o
  typedef struct packed {
    logic                          ok;
    logic [ssba_pkg::SLOT_W-1:0]   slot;
    logic [ssba_pkg::SECTOR_W-1:0] sector;
    logic                          last;
  } sector_beat_t;

  // slot map mirror and queue of sector beats still owed by the block
  class slot_run_board;
    bit [ssba_pkg::MAX_SLOTS-1:0] used_slots;
    logic [ssba_pkg::COUNT_W-1:0] slot_count;
    sector_beat_t                 owed_beats[$];
    int                           errors;

    function new();
      used_slots = '0;
      slot_count = ssba_pkg::SLOT_COUNT_RST;
      errors     = 0;
    endfunction

    function int usable();
      return (slot_count > ssba_pkg::MAX_SLOTS) ? ssba_pkg::MAX_SLOTS : int'(slot_count);
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    // full sector run of one slot
    function void push_run(logic [ssba_pkg::SLOT_W-1:0] s);
      sector_beat_t b;
      for (int k = 0; k < ssba_pkg::RUN_LEN; k++) begin
        b.ok     = 1'b1;
        b.slot   = s;
        b.sector = ssba_pkg::SECTOR_W'(int'(s) * ssba_pkg::SECTORS_PER_PAGE + k);
        b.last   = (k == ssba_pkg::RUN_LEN - 1);
        owed_beats.push_back(b);
      end
    endfunction

    // single failure beat
    function void push_fail(logic [ssba_pkg::SLOT_W-1:0] s);
      sector_beat_t b;
      b.ok     = 1'b0;
      b.slot   = s;
      b.sector = '0;
      b.last   = 1'b1;
      owed_beats.push_back(b);
    endfunction

    // accepted request: update the map, queue its beats
    function void note_request(logic kind, logic [ssba_pkg::SLOT_W-1:0] idx);
      int lim;
      lim = usable();
      if (kind == ssba_pkg::REQ_ALLOC) begin
        for (int s = 0; s < lim; s++) begin
          if (!used_slots[s]) begin
            used_slots[s] = 1'b1;
            push_run(ssba_pkg::SLOT_W'(s));
            return;
          end
        end
        push_fail('0);
      end else if (int'(idx) >= lim || !used_slots[idx]) begin
        push_fail(idx);
      end else begin
        used_slots[idx] = 1'b0;
        push_run(idx);
      end
    endfunction

    // random slot in use below the limit, else a slot below the limit, else any slot
    function logic [ssba_pkg::SLOT_W-1:0] pick_used();
      int lim;
      int start;
      lim = usable();
      if (lim == 0) return ssba_pkg::SLOT_W'($urandom_range(ssba_pkg::MAX_SLOTS - 1));
      start = $urandom_range(lim - 1);
      for (int i = 0; i < lim; i++) begin
        int s;
        s = (start + i) % lim;
        if (used_slots[s]) return ssba_pkg::SLOT_W'(s);
      end
      return ssba_pkg::SLOT_W'(start);
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one beat with the oldest owed beat
    task check_beat(input sector_beat_t got);
      sector_beat_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("unexpected beat ok=%0b slot=%0d sector=%0d last=%0b",
                         got.ok, got.slot, got.sector, got.last));
        return;
      end
      want = owed_beats.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok %0b, wanted %0b", got.ok, want.ok));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, wanted %0d", got.slot, want.slot));
      if (got.sector !== want.sector)
        report($sformatf("sector %0d, wanted %0d", got.sector, want.sector));
      if (got.last !== want.last)
        report($sformatf("last %0b, wanted %0b", got.last, want.last));
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [ssba_pkg::COUNT_W-1:0] cfg_wdata_i;

  ssba_req_if req_bus ();
  ssba_rsp_if rsp_bus ();

  slot_run_board sb = new();

  bit  no_idle       = 1'b0;
  bit  long_hold_req = 1'b0;
  int  cycle_count   = 0;

  swap_slot_bitmap_allocator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check taken beats, stall in bursts or one long hold
  initial begin : rsp_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_beat({rsp_bus.ok, rsp_bus.slot, rsp_bus.sector, rsp_bus.last});
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // offer one request, note it once taken
  task automatic send_req(input logic kind, input logic [ssba_pkg::SLOT_W-1:0] idx);
    if (!no_idle && $urandom_range(3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.slot_index <= idx;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(kind, idx);
  endtask

  // stop offering and wait for every owed beat
  task automatic wait_drained(input int settle);
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [ssba_pkg::COUNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.slot_count = value;
  endtask

  // random phase: allocates and releases; a release mostly names a slot in use, some any slot
  task automatic run_phase(input logic [ssba_pkg::COUNT_W-1:0] count, input int n_items,
                           input int alloc_pct);
    logic                        kind;
    logic [ssba_pkg::SLOT_W-1:0] idx;
    write_slot_count(count);
    for (int i = 0; i < n_items; i++) begin
      kind = ($urandom_range(99) < alloc_pct) ? ssba_pkg::REQ_ALLOC : ssba_pkg::REQ_RELEASE;
      if (kind == ssba_pkg::REQ_ALLOC || $urandom_range(9) >= 7)
        idx = ssba_pkg::SLOT_W'($urandom_range(ssba_pkg::MAX_SLOTS - 1));
      else
        idx = sb.pick_used();
      send_req(kind, idx);
    end
    wait_drained(CFG_SETTLE);
  endtask

  initial begin : stimulus
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= ssba_pkg::REQ_ALLOC;
    req_bus.slot_index <= '0;
    rsp_bus.ready      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset slot count: releases of free slots, first fit, reuse of a hole
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(0));
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(ssba_pkg::MAX_SLOTS - 1));
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'('h2AA));
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'('h155));
    send_req(ssba_pkg::REQ_ALLOC, '1);
    send_req(ssba_pkg::REQ_ALLOC, '0);
    send_req(ssba_pkg::REQ_ALLOC, ssba_pkg::SLOT_W'('h155));
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(1));
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(1));
    send_req(ssba_pkg::REQ_ALLOC, '0);
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(0));
    send_req(ssba_pkg::REQ_ALLOC, '0);
    wait_drained(CFG_SETTLE);

    // two usable slots: full map, used slot beyond the limit
    write_slot_count(ssba_pkg::COUNT_W'(2));
    send_req(ssba_pkg::REQ_ALLOC, '0);
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(2));
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(1));
    send_req(ssba_pkg::REQ_ALLOC, '0);
    send_req(ssba_pkg::REQ_ALLOC, '0);
    wait_drained(CFG_SETTLE);

    // no usable slots
    write_slot_count('0);
    send_req(ssba_pkg::REQ_ALLOC, '0);
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(0));
    wait_drained(CFG_SETTLE);

    // count above the slot space saturates
    write_slot_count('1);
    send_req(ssba_pkg::REQ_RELEASE, ssba_pkg::SLOT_W'(2));
    send_req(ssba_pkg::REQ_ALLOC, '0);
    send_req(ssba_pkg::REQ_ALLOC, '0);
    wait_drained(CFG_SETTLE);

    // random phases; the first starts with a long result stall
    long_hold_req = 1'b1;
    run_phase(ssba_pkg::COUNT_W'(ssba_pkg::MAX_SLOTS), 90, 70);
    run_phase(ssba_pkg::COUNT_W'(37), 70, 50);
    run_phase('0, 15, 50);
    run_phase(ssba_pkg::COUNT_W'(1), 30, 50);
    run_phase('1, 80, 60);
    run_phase(ssba_pkg::COUNT_W'(33), 45, 45);

    // closing stretch at full rate
    no_idle = 1'b1;
    run_phase(ssba_pkg::COUNT_W'(200), 90, 55);
    wait_drained(END_SETTLE);

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
